@@ src/slp_pkg.sv @@
// shared types and constants for the split lorentzian profile pipeline
`default_nettype none

package slp_pkg;

  // field and datapath widths
  localparam int unsigned POS_W   = 32;
  localparam int unsigned WID_W   = 31;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned DIFF_W  = POS_W + 1;
  localparam int unsigned W2_W    = 2 * WID_W;
  localparam int unsigned AD2_W   = 2 * DIFF_W;
  localparam int unsigned DEN_W   = AD2_W;
  localparam int unsigned HALF_W  = W2_W / 2;
  localparam int unsigned PP_W    = POS_W + HALF_W;
  localparam int unsigned NUM_W   = POS_W + W2_W;
  localparam int unsigned Q_W     = POS_W;
  localparam int unsigned ADDR_W  = 4;

  // quotient bits resolved one per stage
  localparam int unsigned DIV_STAGES = Q_W;

  // accept edge to strobe: six front stages, divider, round, sum
  localparam int unsigned SLP_LATENCY = 6 + DIV_STAGES + 2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_CENTER = 2'd0;
  localparam logic [1:0] REG_LEFT   = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  typedef logic [DEN_W-1:0] den_t;
  typedef logic [Q_W-1:0]   quot_t;

  // per-word side data that rides along the divider
  typedef struct packed {
    logic                    valid;
    logic                    neg;
    logic                    zero;
    logic signed [SUM_W-1:0] sum_in;
  } slp_side_t;

endpackage

`default_nettype wire

@@ src/split_lorentzian_profile.sv @@
// top level: split lorentzian peak evaluator with running sum
//
// Usage:
//   Peak center, left and right half widths and height are set over the
//   APB-style port (byte addresses 0, 4, 8, 12); write them while no word
//   is in flight. pready is always high and reads return the registers.
//   A sample word (sample_position, sum_in) is taken at each rising edge
//   with start high and busy low. The value height*w^2/(w^2+d^2) is
//   rounded half away from zero, and sum_out = sum_in + curve_value,
//   clipped to 48 bits with sum_saturated flagging the clip.
//   Throughput: one word per cycle, fully pipelined.
//   done is high for a single cycle with each result, which passes
//   the front end multipliers, the 32-stage divider (one quotient bit
//   per stage) and the rounding and sum stages.
//   The receiver cannot stall; every result shows exactly once.
//   Reset (synchronous, active high) drops words in flight and restores
//   the register defaults; busy is high only while reset is held.
`default_nettype none

module split_lorentzian_profile (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // sample channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [slp_pkg::POS_W-1:0]  sample_position,
  input  wire logic signed [slp_pkg::SUM_W-1:0]  sum_in,
  // result channel
  output logic                                   done,
  output logic signed [slp_pkg::POS_W-1:0]       curve_value,
  output logic signed [slp_pkg::SUM_W-1:0]       sum_out,
  output logic                                   sum_saturated,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [slp_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import slp_pkg::*;

  // configuration registers
  logic signed [POS_W-1:0] center_position;
  logic [WID_W-1:0]        hwhm_left;
  logic [WID_W-1:0]        hwhm_right;
  logic signed [POS_W-1:0] peak_height;
  logic [1:0]              reg_index;
  logic                    wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_position <= '0;
      hwhm_left       <= WID_W'(65536);
      hwhm_right      <= WID_W'(65536);
      peak_height     <= POS_W'(65536);
    end else if (wr_en) begin
      unique case (reg_index)
        REG_CENTER: center_position <= pwdata;
        REG_LEFT:   hwhm_left       <= pwdata[WID_W-1:0];
        REG_RIGHT:  hwhm_right      <= pwdata[WID_W-1:0];
        REG_HEIGHT: peak_height     <= pwdata;
        default:    center_position <= center_position;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_index)
      REG_CENTER: prdata = center_position;
      REG_LEFT:   prdata = {1'b0, hwhm_left};
      REG_RIGHT:  prdata = {1'b0, hwhm_right};
      REG_HEIGHT: prdata = peak_height;
      default:    prdata = '0;
    endcase
  end

  assign busy = rst;

  // stage 1: input capture
  logic                    s1_valid;
  logic signed [POS_W-1:0] s1_x;
  logic signed [SUM_W-1:0] s1_sum;

  // stage 2: offset, width select, magnitudes
  slp_side_t           s2_side;
  logic [DIFF_W-1:0]   s2_ad;
  logic [WID_W-1:0]    s2_w;
  logic [POS_W-1:0]    s2_ah;

  // stage 3: squares
  slp_side_t           s3_side;
  logic [W2_W-1:0]     s3_w2;
  logic [AD2_W-1:0]    s3_ad2;
  logic [POS_W-1:0]    s3_ah;

  // stage 4: denominator, low partial product
  slp_side_t           s4_side;
  den_t                s4_den;
  logic [PP_W-1:0]     s4_plo;
  logic [HALF_W-1:0]   s4_w2hi;
  logic [POS_W-1:0]    s4_ah;

  // stage 5: high partial product
  slp_side_t           s5_side;
  den_t                s5_den;
  logic [PP_W-1:0]     s5_plo;
  logic [PP_W-1:0]     s5_phi;

  // stage 6: numerator split into divider start remainder and low bits
  slp_side_t           s6_side;
  den_t                s6_den;
  den_t                s6_rem;
  quot_t               s6_low;

  logic signed [DIFF_W-1:0] d_next;
  logic [NUM_W-1:0]         num_next;

  always_comb begin
    d_next   = DIFF_W'(s1_x) - DIFF_W'(center_position);
    num_next = NUM_W'(s5_plo) + (NUM_W'(s5_phi) << HALF_W);
  end

  // front stages: valid bits reset, data does not
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_side.valid <= 1'b0;
      s3_side.valid <= 1'b0;
      s4_side.valid <= 1'b0;
      s5_side.valid <= 1'b0;
      s6_side.valid <= 1'b0;
    end else begin
      s1_valid      <= start && !busy;
      s2_side.valid <= s1_valid;
      s3_side.valid <= s2_side.valid;
      s4_side.valid <= s3_side.valid;
      s5_side.valid <= s4_side.valid;
      s6_side.valid <= s5_side.valid;
    end

    s1_x   <= sample_position;
    s1_sum <= sum_in;

    // right width only strictly above the center
    s2_w           <= (s1_x > center_position) ? hwhm_right : hwhm_left;
    s2_side.zero   <= (s1_x > center_position) ? (hwhm_right == '0) : (hwhm_left == '0);
    s2_side.neg    <= peak_height[POS_W-1];
    s2_side.sum_in <= s1_sum;
    s2_ad          <= d_next[DIFF_W-1] ? DIFF_W'(-d_next) : DIFF_W'(d_next);
    s2_ah          <= peak_height[POS_W-1] ? POS_W'(-peak_height) : POS_W'(peak_height);

    s3_w2          <= W2_W'(s2_w) * W2_W'(s2_w);
    s3_ad2         <= AD2_W'(s2_ad) * AD2_W'(s2_ad);
    s3_ah          <= s2_ah;
    {s3_side.neg, s3_side.zero, s3_side.sum_in} <= {s2_side.neg, s2_side.zero, s2_side.sum_in};

    s4_den         <= DEN_W'(s3_w2) + s3_ad2;
    s4_plo         <= PP_W'(s3_ah) * PP_W'(s3_w2[HALF_W-1:0]);
    s4_w2hi        <= s3_w2[W2_W-1:HALF_W];
    s4_ah          <= s3_ah;
    {s4_side.neg, s4_side.zero, s4_side.sum_in} <= {s3_side.neg, s3_side.zero, s3_side.sum_in};

    s5_phi         <= PP_W'(s4_ah) * PP_W'(s4_w2hi);
    s5_plo         <= s4_plo;
    s5_den         <= s4_den;
    {s5_side.neg, s5_side.zero, s5_side.sum_in} <= {s4_side.neg, s4_side.zero, s4_side.sum_in};

    // quotient fits Q_W bits, so the top part is already below den
    s6_rem         <= DEN_W'(num_next[NUM_W-1:Q_W]);
    s6_low         <= num_next[Q_W-1:0];
    s6_den         <= s5_den;
    {s6_side.neg, s6_side.zero, s6_side.sum_in} <= {s5_side.neg, s5_side.zero, s5_side.sum_in};
  end

  // divider
  quot_t     dv_q;
  den_t      dv_rem;
  den_t      dv_den;
  slp_side_t dv_side;

  slp_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .rem_in   (s6_rem),
    .low_in   (s6_low),
    .den_in   (s6_den),
    .side_in  (s6_side),
    .q_out    (dv_q),
    .rem_out  (dv_rem),
    .den_out  (dv_den),
    .side_out (dv_side)
  );

  // rounding, sign and zero width
  logic                    r_valid;
  logic signed [POS_W-1:0] r_curve;
  logic signed [SUM_W-1:0] r_sum;
  quot_t                   mag_next;
  logic signed [SUM_W:0]   total_next;
  logic                    sat_next;

  always_comb begin
    mag_next = dv_q + Q_W'(({dv_rem, 1'b0} >= {1'b0, dv_den}) ? 1 : 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      r_valid <= dv_side.valid;
      done    <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    r_sum <= dv_side.sum_in;
    if (dv_side.zero) begin
      r_curve <= '0;
    end else if (dv_side.neg) begin
      r_curve <= -mag_next;
    end else begin
      r_curve <= mag_next;
    end
  end

  // running sum with 48-bit clip
  always_comb begin
    total_next = (SUM_W+1)'(r_sum) + (SUM_W+1)'(r_curve);
    sat_next   = (total_next[SUM_W] != total_next[SUM_W-1]);
  end

  always_ff @(posedge clk) begin
    curve_value   <= r_curve;
    sum_saturated <= sat_next;
    if (!sat_next) begin
      sum_out <= total_next[SUM_W-1:0];
    end else if (total_next[SUM_W]) begin
      sum_out <= {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_out <= {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

@@ src/slp_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per register stage
`default_nettype none

module slp_div_pipe (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire slp_pkg::den_t     rem_in,
  input  wire slp_pkg::quot_t    low_in,
  input  wire slp_pkg::den_t     den_in,
  input  wire slp_pkg::slp_side_t side_in,
  output slp_pkg::quot_t         q_out,
  output slp_pkg::den_t          rem_out,
  output slp_pkg::den_t          den_out,
  output slp_pkg::slp_side_t     side_out
);
  import slp_pkg::*;

  den_t      rem  [DIV_STAGES];
  quot_t     low  [DIV_STAGES];
  quot_t     quo  [DIV_STAGES];
  den_t      den  [DIV_STAGES];
  slp_side_t side [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    den_t         src_rem;
    quot_t        src_low;
    quot_t        src_q;
    den_t         src_den;
    slp_side_t    src_side;
    logic [DEN_W:0] trial;
    logic         take;
    den_t         rem_next;

    if (k == 0) begin : g_first
      assign src_rem  = rem_in;
      assign src_low  = low_in;
      assign src_q    = '0;
      assign src_den  = den_in;
      assign src_side = side_in;
    end else begin : g_next
      assign src_rem  = rem[k-1];
      assign src_low  = low[k-1];
      assign src_q    = quo[k-1];
      assign src_den  = den[k-1];
      assign src_side = side[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
      trial    = {src_rem, src_low[Q_W-1]};
      take     = (trial >= {1'b0, src_den});
      rem_next = take ? DEN_W'(trial - {1'b0, src_den}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      rem[k]  <= rem_next;
      low[k]  <= {src_low[Q_W-2:0], 1'b0};
      quo[k]  <= {src_q[Q_W-2:0], take};
      den[k]  <= src_den;
      if (rst) begin
        side[k].valid <= 1'b0;
      end else begin
        side[k] <= src_side;
      end
    end
  end

  assign q_out    = quo[DIV_STAGES-1];
  assign rem_out  = rem[DIV_STAGES-1];
  assign den_out  = den[DIV_STAGES-1];
  assign side_out = side[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ src/slp_checker.sv @@
// port-level checks for the split lorentzian profile block, with bind
`default_nettype none

module slp_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic signed [slp_pkg::SUM_W-1:0]  sum_in,
  input wire logic                              done,
  input wire logic signed [slp_pkg::POS_W-1:0]  curve_value,
  input wire logic signed [slp_pkg::SUM_W-1:0]  sum_out,
  input wire logic                              sum_saturated
);
  import slp_pkg::*;

  // every accepted word yields a strobe after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(SLP_LATENCY) done)
    else $error("accepted word produced no result");

  // no strobe without a matching accept
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, SLP_LATENCY))
    else $error("result without accepted word");

  // a clipped sum sits at one of the 48-bit limits
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    (done && sum_saturated) |->
      (sum_out == {1'b0, {(SUM_W-1){1'b1}}}) || (sum_out == {1'b1, {(SUM_W-1){1'b0}}}))
    else $error("saturated sum not at a limit");

  // an unclipped sum is the incoming sum plus the curve value
  a_sum_exact: assert property (@(posedge clk) disable iff (rst)
    (done && !sum_saturated) |->
      (sum_out == $past(sum_in, SLP_LATENCY) + {{(SUM_W-POS_W){curve_value[POS_W-1]}},
                                               curve_value}))
    else $error("sum does not match incoming sum plus curve");

endmodule

bind split_lorentzian_profile slp_checker u_slp_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .sum_in        (sum_in),
  .done          (done),
  .curve_value   (curve_value),
  .sum_out       (sum_out),
  .sum_saturated (sum_saturated)
);

`default_nettype wire

@@ bench/tb_split_lorentzian_profile.sv @@
// testbench for the split lorentzian profile: directed table, then random words vs. a predictor
`timescale 1ns / 100ps

module tb_split_lorentzian_profile;
  import slp_pkg::*;

  localparam int     HALF_PERIOD   = 10;
  localparam int     RESET_CYCLES  = 11;
  localparam int     NUM_PHASES    = 7;
  localparam int     WORDS_PER_PHASE = 250;
  localparam int     IDLE_LIMIT    = 1000;
  localparam longint SUM_MAX       = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN       = -SUM_MAX - 1;

  // one result word
  typedef struct packed {
    logic signed [POS_W-1:0] curve;
    logic signed [SUM_W-1:0] sum;
    logic                    sat;
  } profile_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    logic [31:0] pos;
    logic [47:0] acc;
    bit          typed;
    profile_t    want;
  } row_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [POS_W-1:0] sample_position = '0;
  logic signed [SUM_W-1:0] sum_in = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy, done, sum_saturated, pready;
  logic signed [POS_W-1:0] curve_value;
  logic signed [SUM_W-1:0] sum_out;
  logic [31:0] prdata;

  // predictor copy of the peak registers
  logic signed [31:0] cfg_center = 32'sd0;
  logic [30:0]        cfg_left   = 31'd65536;
  logic [30:0]        cfg_right  = 31'd65536;
  logic signed [31:0] cfg_height = 32'sd65536;

  profile_t pending_results[$];
  profile_t oldest;
  row_t     stim_rows[$];
  int       errors = 0;
  int       burst_left = 0;

  split_lorentzian_profile DUT (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .sample_position(sample_position), .sum_in(sum_in),
    .done(done), .curve_value(curve_value), .sum_out(sum_out),
    .sum_saturated(sum_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // profile value and saturating sum for one sample word
  function automatic profile_t lorentz_eval(input logic [31:0] pos, input logic [47:0] acc);
    longint       xl, cl, hl, dl, mag, curve_l, total;
    logic [30:0]  w;
    logic [127:0] wsq, den, num, quo, rem;
    profile_t     r;
    xl = longint'($signed(pos));
    cl = longint'(cfg_center);
    hl = longint'(cfg_height);
    dl = xl - cl;
    w = (xl > cl) ? cfg_right : cfg_left;
    curve_l = 0;
    if (w != 0) begin
      wsq = {97'd0, w} * {97'd0, w};
      mag = (dl < 0) ? -dl : dl;
      den = wsq + {64'd0, mag} * {64'd0, mag};
      mag = (hl < 0) ? -hl : hl;
      num = {64'd0, mag} * wsq;
      quo = num / den;
      rem = num % den;
      // round half away from zero on the magnitude
      if ((rem << 1) >= den) quo = quo + 1;
      curve_l = (hl < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    end
    total = longint'($signed(acc)) + curve_l;
    r.sat = 1'b0;
    if (total > SUM_MAX) begin
      total = SUM_MAX;
      r.sat = 1'b1;
    end else if (total < SUM_MIN) begin
      total = SUM_MIN;
      r.sat = 1'b1;
    end
    r.curve = curve_l[31:0];
    r.sum = total[47:0];
    return r;
  endfunction

  // directed table rows
  function automatic row_t word_row(input logic [31:0] pos, input logic [47:0] acc);
    row_t rw;
    rw.kind = ROW_WORD;
    rw.reg_idx = REG_CENTER;
    rw.reg_val = '0;
    rw.pos = pos;
    rw.acc = acc;
    rw.typed = 1'b0;
    rw.want = '0;
    return rw;
  endfunction

  function automatic row_t typed_row(input logic [31:0] pos, input logic [47:0] acc,
                                     input logic [31:0] curve, input logic [47:0] sum,
                                     input logic sat);
    row_t rw;
    rw = word_row(pos, acc);
    rw.typed = 1'b1;
    rw.want.curve = curve;
    rw.want.sum = sum;
    rw.want.sat = sat;
    return rw;
  endfunction

  function automatic row_t reg_row(input logic [1:0] idx, input logic [31:0] val);
    row_t rw;
    rw = word_row('0, '0);
    rw.kind = ROW_REG;
    rw.reg_idx = idx;
    rw.reg_val = val;
    return rw;
  endfunction

  // random field values
  function automatic logic [31:0] pick_position();
    logic [31:0] off;
    off = $urandom >> $urandom_range(0, 31);
    if ($urandom_range(0, 1) == 1) off = -off;
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: return cfg_center;
      3: return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return cfg_center + off;
    endcase
  endfunction

  function automatic logic [47:0] pick_sum();
    logic [47:0] small_off;
    small_off = {16'd0, $urandom} >> $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0: return 48'h7FFF_FFFF_FFFF - small_off;
      1: return 48'h8000_0000_0000 + small_off;
      2: return ($urandom_range(0, 1) == 1) ? small_off : -small_off;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [31:0] pick_width();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0001_0000;
      3: return $urandom;
      // bit 31 is dropped by the register
      default: return ($urandom >> $urandom_range(0, 31)) | ($urandom_range(0, 1) << 31);
    endcase
  endfunction

  function automatic logic [31:0] pick_signed32();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return -($urandom >> $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // one transfer on the configuration port
  task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write a register, read it back, and track it in the predictor
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] masked, rd;
    masked = (idx == REG_LEFT || idx == REG_RIGHT) ? (value & 32'h7FFF_FFFF) : value;
    apb_access(1'b1, idx, value, rd);
    apb_access(1'b0, idx, 32'd0, rd);
    if (rd !== masked) begin
      $error("prdata: expected %h, got %h", masked, rd);
      errors++;
    end
    case (idx)
      REG_CENTER: cfg_center = masked;
      REG_LEFT:   cfg_left = masked[30:0];
      REG_RIGHT:  cfg_right = masked[30:0];
      REG_HEIGHT: cfg_height = masked;
      default: ;
    endcase
  endtask

  // offer one sample word, record its expected result, then maybe idle
  task automatic send_word(input logic [31:0] pos, input logic [47:0] acc, input bit typed,
                           input profile_t want);
    @(negedge clk);
    start <= 1'b1;
    sample_position <= pos;
    sum_in <= acc;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(typed ? want : lorentz_eval(pos, acc));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(0, 12);
    end
  endtask

  // stop offering words and let the pipeline empty
  task automatic drain_words();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected");
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (curve_value !== oldest.curve) begin
          $error("curve_value: expected %0d, got %0d", oldest.curve, curve_value);
          errors++;
        end
        if (sum_out !== oldest.sum) begin
          $error("sum_out: expected %0d, got %0d", oldest.sum, sum_out);
          errors++;
        end
        if (sum_saturated !== oldest.sat) begin
          $error("sum_saturated: expected %0b, got %0b", oldest.sat, sum_saturated);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done || (psel && penable)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    int p, k;
    row_t rw;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: center 0, both widths 1.0, height 1.0
    stim_rows.push_back(typed_row(32'h0000_0000, 48'h0, 32'h0001_0000, 48'h0001_0000, 1'b0));
    stim_rows.push_back(typed_row(32'h0001_0000, 48'h0, 32'h0000_8000, 48'h0000_8000, 1'b0));
    stim_rows.push_back(typed_row(32'hFFFF_0000, 48'hFFFF_FFFF_8000, 32'h0000_8000, 48'h0,
                                  1'b0));
    // sum clips high
    stim_rows.push_back(typed_row(32'h0, 48'h7FFF_FFFF_FFFF, 32'h0001_0000, 48'h7FFF_FFFF_FFFF,
                                  1'b1));
    stim_rows.push_back(typed_row(32'h0, 48'h8000_0000_0000, 32'h0001_0000, 48'h8000_0001_0000,
                                  1'b0));
    stim_rows.push_back(word_row(32'h7FFF_FFFF, 48'h0));
    stim_rows.push_back(word_row(32'h8000_0000, 48'h7FFF_FFFF_FFFF));
    // most negative height, sum clips low
    stim_rows.push_back(reg_row(REG_HEIGHT, 32'h8000_0000));
    stim_rows.push_back(typed_row(32'h0, 48'h8000_0000_0000, 32'h8000_0000, 48'h8000_0000_0000,
                                  1'b1));
    stim_rows.push_back(typed_row(32'h0, 48'h0, 32'h8000_0000, 48'hFFFF_8000_0000, 1'b0));
    stim_rows.push_back(typed_row(32'h0001_0000, 48'h0, 32'hC000_0000, 48'hFFFF_C000_0000,
                                  1'b0));
    // zero right width
    stim_rows.push_back(reg_row(REG_RIGHT, 32'h0));
    stim_rows.push_back(typed_row(32'h0000_0001, 48'd12345, 32'h0, 48'd12345, 1'b0));
    stim_rows.push_back(word_row(32'h0, 48'h0));
    // widest left width, written with bit 31 set
    stim_rows.push_back(reg_row(REG_LEFT, 32'hFFFF_FFFF));
    stim_rows.push_back(word_row(32'h8000_0000, 48'h1234_5678_9ABC));
    stim_rows.push_back(word_row(32'hFFFF_FFFF, 48'hFEDC_BA98_7654));
    // center at the top end, sample at center
    stim_rows.push_back(reg_row(REG_CENTER, 32'h7FFF_FFFF));
    stim_rows.push_back(reg_row(REG_HEIGHT, 32'h7FFF_FFFF));
    stim_rows.push_back(typed_row(32'h7FFF_FFFF, 48'h0, 32'h7FFF_FFFF, 48'h0000_7FFF_FFFF,
                                  1'b0));
    stim_rows.push_back(word_row(32'h8000_0000, 48'h0));
    // center at the bottom end
    stim_rows.push_back(reg_row(REG_CENTER, 32'h8000_0000));
    stim_rows.push_back(typed_row(32'h8000_0000, 48'h0, 32'h7FFF_FFFF, 48'h0000_7FFF_FFFF,
                                  1'b0));
    stim_rows.push_back(typed_row(32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 32'h0, 48'h7FFF_FFFF_FFFF,
                                  1'b0));
    stim_rows.push_back(word_row(32'h0, 48'h5555_AAAA_5555));
    // narrowest widths, rounding ties
    stim_rows.push_back(reg_row(REG_RIGHT, 32'h0000_0001));
    stim_rows.push_back(reg_row(REG_LEFT, 32'h0000_0001));
    stim_rows.push_back(word_row(32'h8000_0001, 48'h0));
    stim_rows.push_back(word_row(32'h8000_0000, 48'hAAAA_5555_AAAA));
    stim_rows.push_back(reg_row(REG_HEIGHT, 32'hFFFF_FFFF));
    stim_rows.push_back(word_row(32'h8000_0001, 48'h0));
    stim_rows.push_back(word_row(32'h8000_0003, 48'h0));

    foreach (stim_rows[k]) begin
      rw = stim_rows[k];
      if (rw.kind == ROW_REG) begin
        drain_words();
        cfg_write(rw.reg_idx, rw.reg_val);
      end else begin
        send_word(rw.pos, rw.acc, rw.typed, rw.want);
      end
    end

    // random phases, each under a fresh register setting
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_words();
      cfg_write(REG_CENTER, pick_signed32());
      cfg_write(REG_LEFT, pick_width());
      cfg_write(REG_RIGHT, pick_width());
      cfg_write(REG_HEIGHT, pick_signed32());
      for (k = 0; k < WORDS_PER_PHASE; k++) send_word(pick_position(), pick_sum(), 1'b0, '0);
    end

    drain_words();
    repeat (SLP_LATENCY + 8) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
src/slp_pkg.sv
src/slp_div_pipe.sv
src/split_lorentzian_profile.sv
src/slp_checker.sv
bench/tb_split_lorentzian_profile.sv
